### sv/preemptive_priority_scheduler_macros.svh
// Assertion macros for the preemptive priority scheduler.
// Used by the top level only; clk and arst_n must be in scope where expanded.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPS_ASSERT_SAME(lbl, ante, cons, msg)
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; used by pps_cell and preemptive_priority_scheduler.
package pps_pkg;

	localparam int SLOTS    = 16;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W   = 4;
	localparam int CMP_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int TIME_W   = 16;
	localparam int PRIO_W   = 8;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Pending count along the chain saturates here.
	localparam logic [1:0] PEND_SAT = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_len;
		logic [PRIO_W-1:0] priority_req;
	} item_t;

	typedef struct packed {
		logic              cpu_busy;
		logic [SLOT_W-1:0] running_slot;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] response;
		logic              all_done;
		logic [TIME_W-1:0] time_now;
	} result_t;

	// Best candidate so far plus a saturating count of unfinished slots.
	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] first;
		logic              started;
		logic [1:0]        pend;
	} chain_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic              load;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
		logic              upd;
		logic [IDX_W-1:0]  upd_idx;
		logic [TIME_W-1:0] time_now;
	} cmd_t;

endpackage

### sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: top level with sequencer and a row of slot cells.
// A result strobes once the sequencer has passed through SCAN, UPD and FIN for the item.
// busy stays high until the result is registered, so no new item is taken before the last is through.
// Results cannot be stalled; done is high for exactly one cycle per beat.
// Reset (arst_n low) clears all slot marks, the time and the sequencer at once.
// Depends on pps_pkg, pps_cell and preemptive_priority_scheduler_macros.svh.
`include "preemptive_priority_scheduler_macros.svh"
module preemptive_priority_scheduler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pps_pkg::item_t   item,
	output logic             done,
	output pps_pkg::result_t result
);

	// The sequencer walks through four phases for each beat:
	//   IDLE  waits for start; a load beat writes its slot at the accepting edge.
	//   SCAN  lets the best-candidate record ripple through the row of cells,
	//         one cell per cycle, until it has passed every cell. Slot state is frozen meanwhile,
	//         so the record at the last cell is the winner for this tick.
	//   UPD   broadcasts the winner to the cells, which run it for one time unit,
	//         and captures turnaround, response and the all-done flag.
	//   FIN   finishes waiting time and registers the result for the strobe.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [pps_pkg::IDX_W-1:0]     cnt_q;
	logic [pps_pkg::TIME_W-1:0]    time_q;
	logic                          done_q;
	pps_pkg::result_t              result_q;
	pps_pkg::item_t                item_q;

	// Values captured in UPD for the final step.
	logic                          busy_q;
	logic [pps_pkg::SLOT_W-1:0]    run_q;
	logic                          fin_q;
	logic [pps_pkg::TIME_W-1:0]    tat_q;
	logic [pps_pkg::TIME_W-1:0]    resp_q;
	logic [pps_pkg::TIME_W-1:0]    burst_q;
	logic                          alld_q;

	logic                          accept;
	pps_pkg::cmd_t                 cmd;
	pps_pkg::chain_t               link [pps_pkg::SLOTS+1];
	pps_pkg::chain_t               best;
	logic                          tick;
	logic                          run_now;
	logic                          fin_now;
	logic [pps_pkg::TIME_W-1:0]    time_next;
	logic [pps_pkg::TIME_W-1:0]    first_eff;
	logic [pps_pkg::TIME_W-1:0]    wait_val;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign best      = link[pps_pkg::SLOTS];
	assign tick      = (item_q.mode == pps_pkg::MODE_TICK);
	assign run_now   = (state_q == ST_UPD) && tick && best.vld;
	assign fin_now   = run_now && (best.remaining <= pps_pkg::TIME_W'(1));
	// Time stops at its maximum; a tick then still runs one unit of work.
	assign time_next = (time_q == pps_pkg::TIME_MAX) ? time_q :
		time_q + pps_pkg::TIME_W'(1);
	// A slot on its first dispatch starts now.
	assign first_eff = best.started ? best.first : time_q;
	// Waiting is floored at zero, which matters when time has saturated.
	assign wait_val  = (tat_q > burst_q) ? tat_q - burst_q : '0;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (item.mode == pps_pkg::MODE_LOAD);
		cmd.slot     = item.slot;
		cmd.arrival  = item.arrival_time;
		cmd.burst    = item.burst_len;
		cmd.prio     = item.priority_req;
		cmd.upd      = run_now;
		cmd.upd_idx  = best.idx;
		cmd.time_now = time_q;
	end

	// Nothing enters the head of the chain: the first ready cell always takes over.
	assign link[0] = '0;

	for (genvar i = 0; i < pps_pkg::SLOTS; i++) begin : g_cell
		pps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (pps_pkg::IDX_W'(i)),
			.cmd    (cmd),
			.prev   (link[i]),
			.next   (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			time_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + pps_pkg::IDX_W'(1);
					if (cnt_q == pps_pkg::IDX_W'(pps_pkg::SLOTS - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (tick) begin
						time_q <= time_next;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					result_q.cpu_busy     <= busy_q;
					result_q.running_slot <= run_q;
					result_q.finished     <= fin_q;
					result_q.turnaround   <= tat_q;
					result_q.waiting      <= fin_q ? wait_val : '0;
					result_q.response     <= resp_q;
					result_q.all_done     <= alld_q;
					result_q.time_now     <= time_q;
					done_q                <= 1'b1;
					state_q               <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_UPD) begin
			busy_q  <= run_now;
			run_q   <= run_now ? pps_pkg::SLOT_W'(best.idx) : '0;
			fin_q   <= fin_now;
			tat_q   <= fin_now ? time_next - best.arrival : '0;
			resp_q  <= fin_now ? first_eff - best.arrival : '0;
			burst_q <= best.burst;
			// A finishing winner was itself counted as pending.
			alld_q  <= fin_now ? (best.pend == 2'd1) : (best.pend == 2'd0);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PPS_ASSERT_NEXT(a_strobe_after_fin, state_q == ST_FIN, done_q, "strobe missing after FIN")
	`PPS_ASSERT_SAME(a_strobe_only_after_fin, done_q, $past(state_q == ST_FIN), "stray strobe")
	`PPS_ASSERT_NEXT(a_load_never_runs, (state_q == ST_FIN) && !tick, !result_q.cpu_busy,
		"load beat reported a dispatch")
	`PPS_ASSERT_SAME(a_finish_needs_run, done_q && result_q.finished, result_q.cpu_busy,
		"finish without dispatch")
	`PPS_ASSERT_NEXT(a_time_monotonic, state_q == ST_UPD, time_q >= $past(time_q),
		"time went backward")

endmodule

### sv/pps_cell.sv
// One process slot of the scheduler, with one stage of the selection chain.
// Depends on pps_pkg.
module pps_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [pps_pkg::IDX_W-1:0] my_idx,
	input  pps_pkg::cmd_t            cmd,
	input  pps_pkg::chain_t          prev,
	output pps_pkg::chain_t          next
);

	logic                            valid_q;
	logic                            done_q;
	logic                            started_q;
	logic [pps_pkg::TIME_W-1:0]      arrival_q;
	logic [pps_pkg::TIME_W-1:0]      burst_q;
	logic [pps_pkg::TIME_W-1:0]      remaining_q;
	logic [pps_pkg::TIME_W-1:0]      first_q;
	logic [pps_pkg::PRIO_W-1:0]      prio_q;
	pps_pkg::chain_t                 out_q;
	pps_pkg::chain_t                 stage;

	logic match_load;
	logic match_upd;
	logic pending;
	logic ready;
	logic take;
	logic last_unit;

	assign match_load = cmd.load &&
		(pps_pkg::CMP_W'(cmd.slot) == pps_pkg::CMP_W'(my_idx));
	assign match_upd  = cmd.upd && (cmd.upd_idx == my_idx);
	assign pending    = valid_q && !done_q;
	assign ready      = pending && (arrival_q <= cmd.time_now);
	assign take       = ready && (!prev.vld || (prio_q < prev.prio));
	assign last_unit  = (remaining_q <= pps_pkg::TIME_W'(1));

	always_comb begin
		stage = prev;
		if (take) begin
			stage.vld       = 1'b1;
			stage.idx       = my_idx;
			stage.prio      = prio_q;
			stage.arrival   = arrival_q;
			stage.burst     = burst_q;
			stage.remaining = remaining_q;
			stage.first     = first_q;
			stage.started   = started_q;
		end
		if (pending && (prev.pend != pps_pkg::PEND_SAT)) begin
			stage.pend = prev.pend + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			done_q    <= 1'b0;
			started_q <= 1'b0;
			out_q     <= '0;
		end else begin
			out_q <= stage;
			if (match_load) begin
				valid_q   <= 1'b1;
				done_q    <= 1'b0;
				started_q <= 1'b0;
			end else if (match_upd) begin
				started_q <= 1'b1;
				if (last_unit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match_load) begin
			arrival_q   <= cmd.arrival;
			burst_q     <= cmd.burst;
			remaining_q <= cmd.burst;
			prio_q      <= cmd.prio;
		end else if (match_upd) begin
			if (!started_q) begin
				first_q <= cmd.time_now;
			end
			remaining_q <= last_unit ? '0 : remaining_q - pps_pkg::TIME_W'(1);
		end
	end

	assign next = out_q;

endmodule
